// File: sv/chacha20_stream_cipher_defines.svh
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher assertion macros
// Shared assertion forms, clocked on clk and quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHACHA20_STREAM_CIPHER_DEFINES_SVH
`define CHACHA20_STREAM_CIPHER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CC20_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CC20_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/cc20_pkg.sv
// ----------------------------------------------------------------------------
// ChaCha20 package
// Constants, types and register codes shared by the cipher modules.
// ----------------------------------------------------------------------------
package cc20_pkg;

	localparam int DOUBLE_ROUNDS = 10;
	localparam int NUM_ROUNDS    = 2 * DOUBLE_ROUNDS;
	localparam int ROUND_W       = $clog2(NUM_ROUNDS);

	localparam int DATA_W  = 64;
	localparam int CNT_W   = 4;
	localparam int BYTES   = 8;
	localparam int WORDS   = 16;
	localparam int POS_W   = 3;
	localparam int ADDR_W  = 6;
	localparam int PDATA_W = 64;

	localparam logic [31:0] SIGMA0 = 32'h6170_7865;
	localparam logic [31:0] SIGMA1 = 32'h3320_646e;
	localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
	localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

	localparam logic [2:0] REG_KEY0     = 3'd0;
	localparam logic [2:0] REG_KEY1     = 3'd1;
	localparam logic [2:0] REG_KEY2     = 3'd2;
	localparam logic [2:0] REG_KEY3     = 3'd3;
	localparam logic [2:0] REG_NONCE0   = 3'd4;
	localparam logic [2:0] REG_NONCE1   = 3'd5;
	localparam logic [2:0] REG_INIT_CTR = 3'd6;

	typedef logic [31:0] word_t;
	typedef logic [WORDS-1:0][31:0] cc_state_t;

	typedef enum logic [1:0] {
		STEP_AD16,
		STEP_CB12,
		STEP_AD8,
		STEP_CB7
	} step_t;

	typedef struct packed {
		logic [255:0] key;
		logic [95:0]  nonce;
		word_t        init_ctr;
	} cfg_t;

	typedef struct packed {
		logic  start;
		word_t ctr;
	} gen_req_t;

endpackage

// File: sv/cc20_ifs.sv
// ----------------------------------------------------------------------------
// ChaCha20 channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface cc20_in_if;
	import cc20_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_in;
	logic [CNT_W-1:0]  byte_count;
	logic              last_of_message;
	logic              restart;

	modport source (output valid, data_in, byte_count, last_of_message, restart,
		input ready);
	modport sink (input valid, data_in, byte_count, last_of_message, restart,
		output ready);
endinterface

interface cc20_out_if;
	import cc20_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_out;
	logic [CNT_W-1:0]  out_byte_count;
	logic              out_last;

	modport source (output valid, data_out, out_byte_count, out_last, input ready);
	modport sink (input valid, data_out, out_byte_count, out_last, output ready);
endinterface

// File: sv/cc20_apb_regs.sv
// ----------------------------------------------------------------------------
// ChaCha20 configuration registers
// APB register file holding key, nonce and the restart counter value.
// ----------------------------------------------------------------------------
module cc20_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cc20_pkg::ADDR_W-1:0]  paddr,
	input  logic [cc20_pkg::PDATA_W-1:0] pwdata,
	output logic [cc20_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output cc20_pkg::cfg_t               cfg
);
	import cc20_pkg::*;

	logic [3:0][63:0] key_q;
	logic [63:0]      nonce0_q;
	logic [31:0]      nonce1_q;
	logic [31:0]      init_ctr_q;
	logic [2:0]       idx;
	logic             wr_en;

	assign idx    = paddr[5:3];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q      <= '0;
			nonce0_q   <= '0;
			nonce1_q   <= '0;
			init_ctr_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_KEY0:     key_q[0]   <= pwdata;
				REG_KEY1:     key_q[1]   <= pwdata;
				REG_KEY2:     key_q[2]   <= pwdata;
				REG_KEY3:     key_q[3]   <= pwdata;
				REG_NONCE0:   nonce0_q   <= pwdata;
				REG_NONCE1:   nonce1_q   <= pwdata[31:0];
				REG_INIT_CTR: init_ctr_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_KEY0:     prdata = key_q[0];
			REG_KEY1:     prdata = key_q[1];
			REG_KEY2:     prdata = key_q[2];
			REG_KEY3:     prdata = key_q[3];
			REG_NONCE0:   prdata = nonce0_q;
			REG_NONCE1:   prdata = {32'd0, nonce1_q};
			REG_INIT_CTR: prdata = {32'd0, init_ctr_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.key      = key_q;
	assign cfg.nonce    = {nonce1_q, nonce0_q};
	assign cfg.init_ctr = init_ctr_q;

endmodule

// File: sv/cc20_round_step.sv
// ----------------------------------------------------------------------------
// ChaCha20 round step unit
// Applies one add-xor-rotate step of the quarter round to four lanes at once.
// ----------------------------------------------------------------------------
module cc20_round_step (
	input  cc20_pkg::cc_state_t st_in,
	input  logic                diag,
	input  cc20_pkg::step_t     step,
	output cc20_pkg::cc_state_t st_out
);
	import cc20_pkg::*;

	logic [3:0] ia [4];
	logic [3:0] ib [4];
	logic [3:0] ic [4];
	logic [3:0] id [4];
	logic       even;

	function automatic word_t rotl(word_t v, step_t s);
		word_t r;
		case (s)
			STEP_AD16: r = {v[15:0], v[31:16]};
			STEP_CB12: r = {v[19:0], v[31:20]};
			STEP_AD8:  r = {v[23:0], v[31:24]};
			STEP_CB7:  r = {v[24:0], v[31:25]};
			default:   r = v;
		endcase
		return r;
	endfunction

	assign even = (step == STEP_AD16) || (step == STEP_AD8);

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			ia[j] = 4'(j);
			ib[j] = diag ? 4'(4 + ((j + 1) & 3)) : 4'(4 + j);
			ic[j] = diag ? 4'(8 + ((j + 2) & 3)) : 4'(8 + j);
			id[j] = diag ? 4'(12 + ((j + 3) & 3)) : 4'(12 + j);
		end
	end

	always_comb begin
		word_t x;
		word_t y;
		word_t z;
		word_t s;
		st_out = st_in;
		for (int j = 0; j < 4; j++) begin
			x = even ? st_in[ia[j]] : st_in[ic[j]];
			y = even ? st_in[ib[j]] : st_in[id[j]];
			z = even ? st_in[id[j]] : st_in[ib[j]];
			s = x + y;
			if (even) begin
				st_out[ia[j]] = s;
				st_out[id[j]] = rotl(z ^ s, step);
			end else begin
				st_out[ic[j]] = s;
				st_out[ib[j]] = rotl(z ^ s, step);
			end
		end
	end

endmodule

// File: sv/cc20_block.sv
// ----------------------------------------------------------------------------
// ChaCha20 block generator
// Sequences the round step unit through all rounds, then adds the input state.
// ----------------------------------------------------------------------------
module cc20_block (
	input  logic                clk,
	input  logic                arst_n,
	input  cc20_pkg::gen_req_t  req,
	input  cc20_pkg::cfg_t      cfg,
	output logic                done,
	output cc20_pkg::cc_state_t ks
);
	import cc20_pkg::*;

	typedef enum logic [1:0] {
		C_IDLE,
		C_RUN,
		C_ADD
	} core_state_t;

	core_state_t          st_q;
	logic [ROUND_W-1:0]   round_q;
	step_t                step_q;
	logic                 done_q;
	cc_state_t            init_q;
	cc_state_t            work_q;
	cc_state_t            init_words;
	cc_state_t            step_out;

	always_comb begin
		init_words[0] = SIGMA0;
		init_words[1] = SIGMA1;
		init_words[2] = SIGMA2;
		init_words[3] = SIGMA3;
		for (int k = 0; k < 8; k++) begin
			init_words[4 + k] = cfg.key[32*k +: 32];
		end
		init_words[12] = req.ctr;
		init_words[13] = cfg.nonce[31:0];
		init_words[14] = cfg.nonce[63:32];
		init_words[15] = cfg.nonce[95:64];
	end

	cc20_round_step u_step (
		.st_in  (work_q),
		.diag   (round_q[0]),
		.step   (step_q),
		.st_out (step_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= C_IDLE;
			round_q <= '0;
			step_q  <= STEP_AD16;
			done_q  <= 1'b0;
		end else begin
			done_q <= (st_q == C_ADD);
			case (st_q)
				C_IDLE: begin
					if (req.start) begin
						init_q  <= init_words;
						work_q  <= init_words;
						round_q <= '0;
						step_q  <= STEP_AD16;
						st_q    <= C_RUN;
					end
				end
				C_RUN: begin
					work_q <= step_out;
					step_q <= step_t'(step_q + 2'd1);
					if (step_q == STEP_CB7) begin
						if (round_q == ROUND_W'(NUM_ROUNDS - 1)) begin
							st_q <= C_ADD;
						end else begin
							round_q <= round_q + 1'b1;
						end
					end
				end
				C_ADD: begin
					for (int k = 0; k < WORDS; k++) begin
						work_q[k] <= work_q[k] + init_q[k];
					end
					st_q <= C_IDLE;
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign ks   = work_q;

endmodule

// File: sv/chacha20_stream_cipher.sv
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher
// XORs message items of up to eight bytes with ChaCha20 keystream.
// ----------------------------------------------------------------------------
// An item whose keystream word is already buffered is accepted in ST_IDLE and
// its result is formed in ST_XOR, which holds while the output register is
// full and not taken. An item that needs a fresh 64-byte block (the first of
// a message, one with restart set, or one that follows eight items served
// from the same block) waits in ST_GEN for the block generator as well, which
// runs its single round step unit, performing one quarter-round step on four
// lanes per cycle, through all rounds and then adds the input state. A finished
// result sits in an output register, so the next item is accepted while it
// waits. Key and nonce are sampled when a block is started.
module chacha20_stream_cipher (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cc20_pkg::ADDR_W-1:0]  paddr,
	input  logic [cc20_pkg::PDATA_W-1:0] pwdata,
	output logic [cc20_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	cc20_in_if.sink                      in_ch,
	cc20_out_if.source                   out_ch
);
	import cc20_pkg::*;
	`include "chacha20_stream_cipher_defines.svh"

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GEN,
		ST_XOR
	} top_state_t;

	top_state_t        st_q;
	logic [DATA_W-1:0] data_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              last_q;
	word_t             ctr_q;
	logic [POS_W-1:0]  pos_q;
	logic              kv_q;
	logic              out_v_q;
	logic [DATA_W-1:0] out_data_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic              out_last_q;

	cfg_t              cfg;
	gen_req_t          req;
	logic              gen_done;
	cc_state_t         ks;
	logic              in_fire;
	logic              need_gen;
	word_t             start_ctr;
	logic [CNT_W-1:0]  cnt_sat;
	logic [DATA_W-1:0] ks_word;
	logic [DATA_W-1:0] mask;
	logic              out_free;

	cc20_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cc20_block u_block (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cfg    (cfg),
		.done   (gen_done),
		.ks     (ks)
	);

	assign in_ch.ready = (st_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign need_gen    = in_ch.restart || !kv_q;
	assign start_ctr   = in_ch.restart ? cfg.init_ctr : ctr_q;
	assign req.start   = in_fire && need_gen;
	assign req.ctr     = start_ctr;
	assign cnt_sat     = (in_ch.byte_count > CNT_W'(BYTES)) ? CNT_W'(BYTES)
		: in_ch.byte_count;
	assign ks_word     = {ks[{pos_q, 1'b1}], ks[{pos_q, 1'b0}]};
	assign out_free    = !out_v_q || out_ch.ready;

	always_comb begin
		for (int i = 0; i < BYTES; i++) begin
			mask[8*i +: 8] = (cnt_q > CNT_W'(i)) ? 8'hff : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			ctr_q   <= '0;
			pos_q   <= '0;
			kv_q    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (st_q == ST_XOR && out_free) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_fire) begin
						data_q <= in_ch.data_in;
						cnt_q  <= cnt_sat;
						last_q <= in_ch.last_of_message;
						if (need_gen) begin
							ctr_q <= start_ctr + 32'd1;
							kv_q  <= 1'b0;
							pos_q <= '0;
							st_q  <= ST_GEN;
						end else begin
							st_q <= ST_XOR;
						end
					end
				end
				ST_GEN: begin
					if (gen_done) begin
						kv_q  <= 1'b1;
						pos_q <= '0;
						st_q  <= ST_XOR;
					end
				end
				ST_XOR: begin
					if (out_free) begin
						out_data_q <= (data_q ^ ks_word) & mask;
						out_cnt_q  <= cnt_q;
						out_last_q <= last_q;
						pos_q      <= last_q ? '0 : pos_q + 1'b1;
						if (last_q || pos_q == POS_W'(BYTES - 1)) begin
							kv_q <= 1'b0;
						end
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid          = out_v_q;
	assign out_ch.data_out       = out_data_q;
	assign out_ch.out_byte_count = out_cnt_q;
	assign out_ch.out_last       = out_last_q;

	`CC20_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ch.ready, "ready stayed high after an accepted item")
	`CC20_ASSERT_SAME(a_done_while_gen, gen_done, st_q == ST_GEN, "block finished outside of generation wait")
	`CC20_ASSERT_SAME(a_count_range, out_v_q, out_cnt_q <= CNT_W'(BYTES), "result byte count above eight")
	`CC20_ASSERT_NEXT(a_gen_clears_buffer, req.start, !kv_q && st_q == ST_GEN, "block start left keystream marked valid")

endmodule
